>>> rtl/core/rrtc_pkg.sv
// Shared types and constants for the RPC retransmit/timeout check pipeline.
// No dependencies.
package rrtc_pkg;

	localparam int unsigned SilW   = 16;
	localparam int unsigned TickW  = 32;
	localparam int unsigned BytesW = 21;
	localparam int unsigned CfgW   = 16;

	localparam logic [SilW-1:0] SilMax = '1;

	localparam logic [1:0] PhaseOutgoing  = 2'd0;
	localparam logic [1:0] PhaseIncoming  = 2'd1;
	localparam logic [1:0] PhaseInService = 2'd2;
	localparam logic [1:0] PhaseOther     = 2'd3;

	typedef enum logic [1:0] {
		REG_RESEND_AFTER  = 2'd0,
		REG_RESEND_PERIOD = 2'd1,
		REG_ABORT_AFTER   = 2'd2,
		REG_ACK_AFTER     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CfgW-1:0] resend_after;
		logic [CfgW-1:0] divisor;
		logic [CfgW-1:0] abort_after;
		logic [CfgW-1:0] ack_request_after;
	} cfg_t;

	typedef struct packed {
		logic              is_client;
		logic [1:0]        rpc_phase;
		logic [BytesW-1:0] bytes_sent;
		logic [BytesW-1:0] out_total;
		logic [BytesW-1:0] out_allowed;
		logic [BytesW-1:0] in_total;
		logic [BytesW-1:0] in_missing;
		logic [BytesW-1:0] in_allowed;
		logic              has_buffers;
		logic [SilW-1:0]   silence_before;
		logic [TickW-1:0]  done_tick;
		logic [TickW-1:0]  now_tick;
	} rpc_t;

	typedef struct packed {
		logic [SilW-1:0]  silence_after;
		logic [TickW-1:0] done_tick_after;
		logic             send_ack_request;
		logic             abort_timeout;
		logic             resend_cand;
		logic [SilW-1:0]  dividend;
		logic [SilW-1:0]  divisor;
		logic [SilW-1:0]  rem;
	} item_t;

endpackage

>>> rtl/core/rrtc_if.sv
// Handshake channels for the RPC retransmit/timeout check.
// Depends on rrtc_pkg.
interface rrtc_rpc_if import rrtc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              is_client;
	logic [1:0]        rpc_phase;
	logic [BytesW-1:0] bytes_sent;
	logic [BytesW-1:0] out_total;
	logic [BytesW-1:0] out_allowed;
	logic [BytesW-1:0] in_total;
	logic [BytesW-1:0] in_missing;
	logic [BytesW-1:0] in_allowed;
	logic              has_buffers;
	logic [SilW-1:0]   silence_before;
	logic [TickW-1:0]  done_tick;
	logic [TickW-1:0]  now_tick;

	modport source (
		output valid, is_client, rpc_phase, bytes_sent, out_total, out_allowed,
			in_total, in_missing, in_allowed, has_buffers, silence_before,
			done_tick, now_tick,
		input ready
	);
	modport sink (
		input valid, is_client, rpc_phase, bytes_sent, out_total, out_allowed,
			in_total, in_missing, in_allowed, has_buffers, silence_before,
			done_tick, now_tick,
		output ready
	);
endinterface

interface rrtc_verdict_if import rrtc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SilW-1:0]  silence_after;
	logic [TickW-1:0] done_tick_after;
	logic             send_ack_request;
	logic             abort_timeout;
	logic             send_resend;

	modport source (
		output valid, silence_after, done_tick_after, send_ack_request,
			abort_timeout, send_resend,
		input ready
	);
	modport sink (
		input valid, silence_after, done_tick_after, send_ack_request,
			abort_timeout, send_resend,
		output ready
	);
endinterface

>>> rtl/core/rrtc_front.sv
// First stage: silence update, quiet/abort decision, done-tick and ack age.
// Depends on rrtc_pkg.
module rrtc_front import rrtc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	input  rpc_t  in_rpc,
	output logic  in_ready,
	output logic  out_valid,
	output item_t out_item,
	input  logic  out_ready
);

	logic              valid_s1;
	item_t             item_s1;
	item_t             item_d;
	logic              in_service;
	logic [SilW-1:0]   sil_inc;
	logic              ack_case;
	logic [TickW-1:0]  age;
	logic signed [BytesW+1:0] rcvd;
	logic signed [BytesW+1:0] grant;
	logic              quiet;
	logic              active;
	logic              abort;

	always_comb begin
		in_service = (in_rpc.rpc_phase == PhaseInService);
		sil_inc    = (in_rpc.silence_before == SilMax) ? in_rpc.silence_before
			: in_rpc.silence_before + SilW'(1);
		ack_case   = !in_service && !in_rpc.is_client
			&& (in_rpc.rpc_phase == PhaseOutgoing)
			&& (in_rpc.bytes_sent == in_rpc.out_total);
		age = in_rpc.done_tick + {{(TickW-CfgW){1'b0}}, cfg.ack_request_after}
			- TickW'(1) - in_rpc.now_tick;
		rcvd  = $signed({2'b00, in_rpc.in_total}) - $signed({2'b00, in_rpc.in_missing});
		grant = $signed({2'b00, in_rpc.in_allowed});
		if (in_rpc.rpc_phase == PhaseIncoming) begin
			quiet = (rcvd >= grant) || !in_rpc.has_buffers;
		end else begin
			quiet = !in_rpc.is_client
				|| ((in_rpc.rpc_phase == PhaseOutgoing)
				&& (in_rpc.bytes_sent < in_rpc.out_allowed));
		end
		active = !in_service && !quiet && (sil_inc >= cfg.resend_after);
		abort  = active && (sil_inc >= cfg.abort_after);

		item_d.silence_after    = (in_service || quiet) ? '0 : sil_inc;
		item_d.done_tick_after  = (ack_case && in_rpc.done_tick == '0) ? in_rpc.now_tick
			: in_rpc.done_tick;
		item_d.send_ack_request = ack_case && (in_rpc.done_tick != '0) && age[TickW-1];
		item_d.abort_timeout    = abort;
		item_d.resend_cand      = active && !abort;
		item_d.dividend         = sil_inc - cfg.resend_after;
		item_d.divisor          = cfg.divisor;
		item_d.rem              = '0;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> rtl/core/rrtc_mod_stage.sv
// One restoring-remainder step: brings in dividend bit BIT, subtracts divisor if it fits.
// Depends on rrtc_pkg.
module rrtc_mod_stage import rrtc_pkg::*; #(
	parameter int unsigned BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  in_ready,
	output logic  out_valid,
	output item_t out_item,
	input  logic  out_ready
);

	logic          valid_s1;
	item_t         item_s1;
	item_t         item_d;
	logic [SilW:0] shifted;

	always_comb begin
		item_d  = in_item;
		shifted = {in_item.rem, in_item.dividend[BIT]};
		if (shifted >= {1'b0, in_item.divisor}) begin
			shifted = shifted - {1'b0, in_item.divisor};
		end
		item_d.rem = shifted[SilW-1:0];
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> rtl/core/rpc_retransmit_timeout_check.sv
// Top level of the RPC retransmit/timeout check: config registers and pipeline.
// Depends on rrtc_pkg, rrtc_if, rrtc_front, rrtc_mod_stage.
//
// Checks one RPC record per beat for one timer tick and returns one verdict
// beat per record, in order. One record is taken every cycle unless the verdict
// side stalls; the first decision stage is followed by a 16-step restoring
// remainder chain (one silence bit per stage) that finds whether the silence
// past resend_after is a multiple of resend_period. Each stage has its own
// valid bit and ready, so bubbles close up under output back-pressure. A
// resend_period of 0 acts as 1. Write config only while no beat is in flight.
module rpc_retransmit_timeout_check import rrtc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	rrtc_rpc_if.sink           rpc,
	rrtc_verdict_if.source     verdict
);

	localparam int unsigned NStages = SilW + 1;

	logic [CfgW-1:0] resend_after_q;
	logic [CfgW-1:0] resend_period_q;
	logic [CfgW-1:0] abort_after_q;
	logic [CfgW-1:0] ack_after_q;
	cfg_t            cfg;
	rpc_t            rpc_in;

	logic  valid_c [NStages];
	logic  ready_c [NStages];
	item_t item_c  [NStages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resend_after_q  <= CfgW'(5);
			resend_period_q <= CfgW'(5);
			abort_after_q   <= CfgW'(100);
			ack_after_q     <= CfgW'(2);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RESEND_AFTER:  resend_after_q  <= cfg_data;
				REG_RESEND_PERIOD: resend_period_q <= cfg_data;
				REG_ABORT_AFTER:   abort_after_q   <= cfg_data;
				REG_ACK_AFTER:     ack_after_q     <= cfg_data;
			endcase
		end
	end

	always_comb begin
		cfg.resend_after      = resend_after_q;
		cfg.divisor           = (resend_period_q == '0) ? CfgW'(1) : resend_period_q;
		cfg.abort_after       = abort_after_q;
		cfg.ack_request_after = ack_after_q;

		rpc_in.is_client      = rpc.is_client;
		rpc_in.rpc_phase      = rpc.rpc_phase;
		rpc_in.bytes_sent     = rpc.bytes_sent;
		rpc_in.out_total      = rpc.out_total;
		rpc_in.out_allowed    = rpc.out_allowed;
		rpc_in.in_total       = rpc.in_total;
		rpc_in.in_missing     = rpc.in_missing;
		rpc_in.in_allowed     = rpc.in_allowed;
		rpc_in.has_buffers    = rpc.has_buffers;
		rpc_in.silence_before = rpc.silence_before;
		rpc_in.done_tick      = rpc.done_tick;
		rpc_in.now_tick       = rpc.now_tick;
	end

	rrtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (rpc.valid),
		.in_rpc    (rpc_in),
		.in_ready  (rpc.ready),
		.out_valid (valid_c[0]),
		.out_item  (item_c[0]),
		.out_ready (ready_c[0])
	);

	for (genvar g = 0; g < SilW; g++) begin : g_mod
		rrtc_mod_stage #(.BIT(SilW - 1 - g)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[g]),
			.in_item   (item_c[g]),
			.in_ready  (ready_c[g]),
			.out_valid (valid_c[g+1]),
			.out_item  (item_c[g+1]),
			.out_ready (ready_c[g+1])
		);
	end

	assign ready_c[SilW]    = verdict.ready;

	assign verdict.valid            = valid_c[SilW];
	assign verdict.silence_after    = item_c[SilW].silence_after;
	assign verdict.done_tick_after  = item_c[SilW].done_tick_after;
	assign verdict.send_ack_request = item_c[SilW].send_ack_request;
	assign verdict.abort_timeout    = item_c[SilW].abort_timeout;
	assign verdict.send_resend      = item_c[SilW].resend_cand && (item_c[SilW].rem == '0);

	a_abort_excl_resend: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid |-> !(verdict.abort_timeout && verdict.send_resend))
		else $error("abort and resend raised together");

	a_flag_needs_silence: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && (verdict.abort_timeout || verdict.send_resend)
		|-> verdict.silence_after != '0)
		else $error("timeout action on a quiet RPC");

	a_ack_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.send_ack_request |-> verdict.done_tick_after != '0)
		else $error("ack request without a recorded done tick");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && !verdict.ready |=> verdict.valid && $stable(item_c[SilW]))
		else $error("final stage changed while stalled");

endmodule

>>> sim/rpc_retransmit_timeout_check_tb.sv
// Self-checking testbench for rpc_retransmit_timeout_check: directed table plus
// constrained-by-hand random records over several register settings.
// Depends on rrtc_pkg, rrtc_if and the block's RTL.
module rpc_retransmit_timeout_check_tb import rrtc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SilW-1:0]  silence_after;
		logic [TickW-1:0] done_tick_after;
		logic             send_ack_request;
		logic             abort_timeout;
		logic             send_resend;
	} verdict_t;

	typedef struct {
		rpc_t     rec;
		bit       typed;
		verdict_t want;
	} stim_row_t;

	localparam int unsigned MaxBytes = 1048576;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;

	rrtc_rpc_if     rpc_ch ();
	rrtc_verdict_if verdict_ch ();

	rpc_retransmit_timeout_check u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rpc       (rpc_ch),
		.verdict   (verdict_ch)
	);

	logic [CfgW-1:0] cfg_resend_after  = 16'd5;
	logic [CfgW-1:0] cfg_resend_period = 16'd5;
	logic [CfgW-1:0] cfg_abort_after   = 16'd100;
	logic [CfgW-1:0] cfg_ack_after     = 16'd2;

	verdict_t  pending_verdicts[$];
	stim_row_t script[$];

	int  mismatch_count = 0;
	int  rpcs_sent      = 0;
	int  verdicts_seen  = 0;
	int  resends_seen   = 0;
	int  aborts_seen    = 0;
	int  acks_seen      = 0;
	bit  calm           = 1'b0;
	bit  hold_request   = 1'b0;
	int  hold_left      = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("rpc_retransmit_timeout_check verification failed");
		$finish;
	end

	function automatic verdict_t predict_verdict(rpc_t r);
		verdict_t    v;
		logic [15:0] sil;
		logic [31:0] done_t;
		logic [31:0] age;
		longint      rcvd;
		bit          quiet;
		int unsigned per;
		int unsigned past;
		v = '0;
		sil = r.silence_before;
		done_t = r.done_tick;
		quiet = 1'b0;
		if (r.rpc_phase == PhaseInService) begin
			sil = '0;
		end else begin
			if (sil != SilMax)
				sil = sil + 16'd1;
			if (!r.is_client && r.rpc_phase == PhaseOutgoing && r.bytes_sent == r.out_total) begin
				if (done_t == 32'd0) begin
					done_t = r.now_tick;
				end else begin
					age = done_t + {16'd0, cfg_ack_after} - 32'd1 - r.now_tick;
					v.send_ack_request = age[31];
				end
			end
			if (r.rpc_phase == PhaseIncoming) begin
				rcvd = longint'(r.in_total) - longint'(r.in_missing);
				if (rcvd >= longint'(r.in_allowed) || !r.has_buffers)
					quiet = 1'b1;
			end else if (!r.is_client) begin
				quiet = 1'b1;
			end
			if (!quiet && r.rpc_phase == PhaseOutgoing && r.bytes_sent < r.out_allowed)
				quiet = 1'b1;
			if (quiet) begin
				sil = '0;
			end else if (sil >= cfg_resend_after) begin
				if (sil >= cfg_abort_after) begin
					v.abort_timeout = 1'b1;
				end else begin
					per = (cfg_resend_period == 0) ? 1 : cfg_resend_period;
					past = sil - cfg_resend_after;
					v.send_resend = (past % per) == 0;
				end
			end
		end
		v.silence_after = sil;
		v.done_tick_after = done_t;
		return v;
	endfunction

	function automatic rpc_t mk_rpc(bit c, int ph, int sent, int tot, int alw, int itot,
			int imiss, int ialw, bit bufs, int sil, logic [31:0] done, logic [31:0] now);
		rpc_t r;
		r.is_client = c;
		r.rpc_phase = ph[1:0];
		r.bytes_sent = sent[20:0];
		r.out_total = tot[20:0];
		r.out_allowed = alw[20:0];
		r.in_total = itot[20:0];
		r.in_missing = imiss[20:0];
		r.in_allowed = ialw[20:0];
		r.has_buffers = bufs;
		r.silence_before = sil[15:0];
		r.done_tick = done;
		r.now_tick = now;
		return r;
	endfunction

	function automatic verdict_t mk_verdict(int sil, logic [31:0] done, bit ack, bit abrt,
			bit rs);
		verdict_t v;
		v.silence_after = sil[15:0];
		v.done_tick_after = done;
		v.send_ack_request = ack;
		v.abort_timeout = abrt;
		v.send_resend = rs;
		return v;
	endfunction

	task automatic add_row(rpc_t r, bit typed, verdict_t w);
		stim_row_t row;
		row.rec = r;
		row.typed = typed;
		row.want = w;
		script.push_back(row);
	endtask

	function automatic logic [20:0] clip_bytes(int v);
		if (v < 0)
			v = 0;
		if (v > MaxBytes)
			v = MaxBytes;
		return v[20:0];
	endfunction

	function automatic logic [20:0] rand_bytes();
		case ($urandom_range(5))
			0: return 21'd0;
			1: return 21'd1;
			2: return 21'd1048575;
			3: return 21'd1048576;
			4: return 21'($urandom_range(4096));
			default: return 21'($urandom_range(MaxBytes));
		endcase
	endfunction

	function automatic logic [15:0] rand_silence();
		int per;
		int v;
		per = (cfg_resend_period == 0) ? 1 : cfg_resend_period;
		case ($urandom_range(7))
			0, 1: v = cfg_resend_after + $urandom_range(4) * per - 2 + $urandom_range(2);
			2: v = cfg_abort_after - 2 + $urandom_range(2);
			3: v = 65535 - $urandom_range(1);
			4: v = $urandom_range(3);
			5: v = $urandom_range(65535);
			default: v = $urandom_range(cfg_abort_after + 4);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	function automatic rpc_t rand_rpc();
		rpc_t r;
		int   rcvd;
		int   sel;
		r.is_client = 1'($urandom_range(1));
		sel = $urandom_range(9);
		r.rpc_phase = (sel < 3) ? PhaseOutgoing : (sel < 6) ? PhaseIncoming :
			(sel == 6) ? PhaseInService : PhaseOther;
		r.bytes_sent = rand_bytes();
		r.out_total = ($urandom_range(9) < 6) ? r.bytes_sent : rand_bytes();
		case ($urandom_range(3))
			0: r.out_allowed = r.bytes_sent;
			1: r.out_allowed = clip_bytes(int'(r.bytes_sent) + 1);
			2: r.out_allowed = clip_bytes(int'(r.bytes_sent) - 1);
			default: r.out_allowed = rand_bytes();
		endcase
		r.in_total = rand_bytes();
		r.in_missing = ($urandom_range(4) == 0) ? rand_bytes() :
			21'($urandom_range(int'(r.in_total)));
		rcvd = int'(r.in_total) - int'(r.in_missing);
		case ($urandom_range(3))
			0: r.in_allowed = clip_bytes(rcvd);
			1: r.in_allowed = clip_bytes(rcvd + 1);
			2: r.in_allowed = clip_bytes(rcvd - 1);
			default: r.in_allowed = rand_bytes();
		endcase
		r.has_buffers = $urandom_range(4) != 0;
		r.silence_before = rand_silence();
		case ($urandom_range(3))
			0: r.now_tick = $urandom_range(3);
			1: r.now_tick = 32'hFFFF_FFFF - $urandom_range(3);
			default: r.now_tick = $urandom;
		endcase
		case ($urandom_range(4))
			0: r.done_tick = '0;
			1, 2: r.done_tick = r.now_tick - {16'd0, cfg_ack_after} + $urandom_range(3);
			3: r.done_tick = $urandom;
			default: r.done_tick = r.now_tick;
		endcase
		return r;
	endfunction

	task automatic program_regs(logic [15:0] ra, logic [15:0] rp, logic [15:0] ab,
			logic [15:0] ack);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_RESEND_AFTER;
		cfg_data <= ra;
		@(negedge clk);
		cfg_index <= REG_RESEND_PERIOD;
		cfg_data <= rp;
		@(negedge clk);
		cfg_index <= REG_ABORT_AFTER;
		cfg_data <= ab;
		@(negedge clk);
		cfg_index <= REG_ACK_AFTER;
		cfg_data <= ack;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_resend_after = ra;
		cfg_resend_period = rp;
		cfg_abort_after = ab;
		cfg_ack_after = ack;
		@(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_rpc(rpc_t r, bit typed, verdict_t want);
		while (!calm && $urandom_range(99) < 16) begin
			rpc_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rpc_ch.valid <= 1'b1;
		rpc_ch.is_client <= r.is_client;
		rpc_ch.rpc_phase <= r.rpc_phase;
		rpc_ch.bytes_sent <= r.bytes_sent;
		rpc_ch.out_total <= r.out_total;
		rpc_ch.out_allowed <= r.out_allowed;
		rpc_ch.in_total <= r.in_total;
		rpc_ch.in_missing <= r.in_missing;
		rpc_ch.in_allowed <= r.in_allowed;
		rpc_ch.has_buffers <= r.has_buffers;
		rpc_ch.silence_before <= r.silence_before;
		rpc_ch.done_tick <= r.done_tick;
		rpc_ch.now_tick <= r.now_tick;
		do
			@(posedge clk);
		while (!rpc_ch.ready);
		pending_verdicts.push_back(typed ? want : predict_verdict(r));
		rpcs_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		rpc_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (20) @(negedge clk);
	endtask

	// Sink side: random back-pressure plus one long hold-off on request.
	initial begin
		verdict_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				verdict_ch.ready <= 1'b0;
			end else begin
				verdict_ch.ready <= calm || ($urandom_range(99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			got.silence_after = verdict_ch.silence_after;
			got.done_tick_after = verdict_ch.done_tick_after;
			got.send_ack_request = verdict_ch.send_ack_request;
			got.abort_timeout = verdict_ch.abort_timeout;
			got.send_resend = verdict_ch.send_resend;
			verdicts_seen++;
			resends_seen += got.send_resend;
			aborts_seen += got.abort_timeout;
			acks_seen += got.send_ack_request;
			if (pending_verdicts.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected verdict beat: sil=%0d done=%0h ack=%0b abort=%0b rs=%0b",
						got.silence_after, got.done_tick_after, got.send_ack_request,
						got.abort_timeout, got.send_resend);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.silence_after !== want.silence_after ||
						got.done_tick_after !== want.done_tick_after ||
						got.send_ack_request !== want.send_ack_request ||
						got.abort_timeout !== want.abort_timeout ||
						got.send_resend !== want.send_resend) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("verdict %0d mismatch: exp sil=%0d done=%0h ack=%0b abort=%0b rs=%0b",
							verdicts_seen, want.silence_after, want.done_tick_after,
							want.send_ack_request, want.abort_timeout, want.send_resend);
						$display("    got sil=%0d done=%0h ack=%0b abort=%0b rs=%0b",
							got.silence_after, got.done_tick_after, got.send_ack_request,
							got.abort_timeout, got.send_resend);
					end
				end
			end
		end
	end

	initial begin
		logic [15:0] ra, rp, ab, ack;
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_RESEND_AFTER;
		cfg_data <= '0;
		rpc_ch.valid <= 1'b0;
		rpc_ch.is_client <= 1'b0;
		rpc_ch.rpc_phase <= PhaseOutgoing;
		rpc_ch.bytes_sent <= '0;
		rpc_ch.out_total <= '0;
		rpc_ch.out_allowed <= '0;
		rpc_ch.in_total <= '0;
		rpc_ch.in_missing <= '0;
		rpc_ch.in_allowed <= '0;
		rpc_ch.has_buffers <= 1'b0;
		rpc_ch.silence_before <= '0;
		rpc_ch.done_tick <= '0;
		rpc_ch.now_tick <= '0;

		// Directed rows run with the reset register values.
		add_row(mk_rpc(0, 2, 0, 0, 0, 0, 0, 0, 0, 1234, 77, 78), 1,
			mk_verdict(0, 77, 0, 0, 0));
		add_row(mk_rpc(1, 3, 0, 0, 0, 0, 0, 0, 1, 65535, 5, 9), 1,
			mk_verdict(65535, 5, 0, 1, 0));
		add_row(mk_rpc(1, 3, 0, 0, 0, 0, 0, 0, 1, 3, 0, 9), 1, mk_verdict(4, 0, 0, 0, 0));
		add_row(mk_rpc(1, 3, 0, 0, 0, 0, 0, 0, 1, 4, 0, 9), 1, mk_verdict(5, 0, 0, 0, 1));
		add_row(mk_rpc(1, 3, 0, 0, 0, 0, 0, 0, 1, 9, 0, 9), 1, mk_verdict(10, 0, 0, 0, 1));
		add_row(mk_rpc(1, 3, 0, 0, 0, 0, 0, 0, 1, 10, 0, 9), 1, mk_verdict(11, 0, 0, 0, 0));
		add_row(mk_rpc(1, 3, 0, 0, 0, 0, 0, 0, 1, 98, 0, 9), 1, mk_verdict(99, 0, 0, 0, 0));
		add_row(mk_rpc(1, 3, 0, 0, 0, 0, 0, 0, 1, 99, 0, 9), 1, mk_verdict(100, 0, 0, 1, 0));
		add_row(mk_rpc(0, 3, 0, 0, 0, 0, 0, 0, 1, 50, 0, 9), 1, mk_verdict(0, 0, 0, 0, 0));
		add_row(mk_rpc(0, 0, 100, 100, 0, 0, 0, 0, 1, 7, 0, 1000), 1,
			mk_verdict(0, 1000, 0, 0, 0));
		add_row(mk_rpc(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_verdict(0, 0, 0, 0, 0));
		add_row(mk_rpc(0, 0, 500, 500, 0, 0, 0, 0, 1, 3, 998, 1000), 1,
			mk_verdict(0, 998, 1, 0, 0));
		add_row(mk_rpc(0, 0, 500, 500, 0, 0, 0, 0, 1, 3, 999, 1000), 1,
			mk_verdict(0, 999, 0, 0, 0));
		add_row(mk_rpc(0, 0, 500, 500, 0, 0, 0, 0, 1, 3, 32'hFFFF_FFFF, 1), 0, '0);
		add_row(mk_rpc(0, 0, 500, 500, 0, 0, 0, 0, 1, 3, 32'hFFFF_FFFF, 0), 0, '0);
		add_row(mk_rpc(1, 1, 0, 0, 0, 1000, 200, 800, 1, 20, 0, 5), 0, '0);
		add_row(mk_rpc(1, 1, 0, 0, 0, 1000, 200, 801, 1, 20, 0, 5), 0, '0);
		add_row(mk_rpc(1, 1, 0, 0, 0, 0, 1000, 0, 1, 4, 0, 5), 0, '0);
		add_row(mk_rpc(1, 1, 0, 0, 0, 1000, 0, 2000, 0, 30, 0, 5), 0, '0);
		add_row(mk_rpc(1, 0, 300, 1000, 301, 0, 0, 0, 1, 9, 0, 5), 0, '0);
		add_row(mk_rpc(1, 0, 301, 1000, 301, 0, 0, 0, 1, 9, 0, 5), 0, '0);
		add_row(mk_rpc(0, 1, 500, 500, 0, 10, 0, 20, 1, 14, 0, 5), 0, '0);
		add_row(mk_rpc(1, 0, 700, 700, 0, 0, 0, 0, 1, 64, 33, 40), 0, '0);
		add_row(mk_rpc(1, 3, MaxBytes, MaxBytes, MaxBytes, MaxBytes, MaxBytes, MaxBytes, 1,
			65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '0);
		add_row(mk_rpc(0, 0, MaxBytes, MaxBytes, MaxBytes, MaxBytes, MaxBytes, MaxBytes, 1,
			65534, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i])
			send_rpc(script[i].rec, script[i].typed, script[i].want);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin ra = 16'd1;     rp = 16'd0;     ab = 16'd65535; ack = 16'd1;     end
				1: begin ra = 16'd65535; rp = 16'd65535; ab = 16'd65535; ack = 16'd65535; end
				2: begin ra = 16'd1;     rp = 16'd1;     ab = 16'd1;     ack = 16'd1;     end
				3: begin ra = 16'd3;     rp = 16'd4;     ab = 16'd20;    ack = 16'd5;     end
				default: begin
					ra = 16'($urandom_range(30, 1));
					rp = 16'($urandom_range(10));
					ab = ($urandom_range(3) == 0) ? ra : 16'($urandom_range(80, 1));
					ack = ($urandom_range(3) == 0) ? 16'd65535 : 16'($urandom_range(10, 1));
				end
			endcase
			program_regs(ra, rp, ab, ack);
			calm = (ph == 2);
			for (int i = 0; i < 85; i++) begin
				if (ph == 3 && i == 20)
					hold_request = 1'b1;
				send_rpc(rand_rpc(), 1'b0, '0);
			end
			drain();
		end
		calm = 1'b0;

		mismatch_count += pending_verdicts.size();
		$display("%0d records checked over 9 register settings, %0d verdict beats compared",
			rpcs_sent, verdicts_seen);
		$display("flags seen: %0d resend, %0d abort, %0d ack request; %0d mismatches",
			resends_seen, aborts_seen, acks_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("rpc_retransmit_timeout_check verification clean");
		else
			$display("rpc_retransmit_timeout_check verification failed");
		$finish;
	end

endmodule
